// ===== design/cipr_pkg.sv =====
package cipr_pkg;

  // Configuration register map
  localparam int unsigned CfgAddrW = 3;
  localparam logic [0:0] RegPayloadSize = 1'b0;

  localparam logic [7:0] PayloadSizeReset = 8'd58;
  localparam logic [7:0] PayloadSizeMax   = 8'd249;
  localparam logic [7:0] PayloadSizeMin   = 8'd1;

  // Package framing: 4 header bytes, 2 trailer bytes
  localparam logic [7:0] PkgOverhead  = 8'd6;
  localparam logic [7:0] PkgMinLength = 8'd7;
  localparam logic [7:0] PkgHeadLen   = 8'd4;

  localparam logic [15:0] GoodbyeCode = 16'hF0F0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        image_last;
    logic        request_valid;
    logic [15:0] request_package;
    logic        goodbye_valid;
    logic [23:0] image_size;
    logic        size_valid;
    logic        size_error;
  } out_item_t;

  // Picture acknowledge pattern AA 0E 04
  function automatic logic [7:0] ack_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'hAA;
      2'd1:    val = 8'h0E;
      2'd2:    val = 8'h04;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== design/cipr_ctrl.sv =====
module cipr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  cipr_pkg::in_item_t in_item_i,
  input  logic [7:0]         payload_size_i,
  output cipr_pkg::out_item_t result_o
);

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhAck   = 2'd1;
  localparam logic [1:0] PhReply = 2'd2;
  localparam logic [1:0] PhPkg   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  match_q, match_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  len_q, len_d;
  logic [23:0] rem_q, rem_d;
  logic [15:0] pkgnum_q, pkgnum_d;
  logic [23:0] gather_q, gather_d;

  logic [7:0]  eff_payload;
  logic [23:0] rem_src;
  logic [7:0]  next_len;
  logic [7:0]  len_eff;
  logic [8:0]  idx_p1;
  logic [8:0]  idx_p2;
  logic        emit;
  logic [23:0] rem_dec;
  logic [15:0] pkgnum_inc;
  logic        ack_hit;
  logic [7:0]  b;

  assign b = in_item_i.rx_byte;

  // Clamp configured payload size to 1..249
  always_comb begin
    if (payload_size_i == 8'd0) begin
      eff_payload = cipr_pkg::PayloadSizeMin;
    end else if (payload_size_i > cipr_pkg::PayloadSizeMax) begin
      eff_payload = cipr_pkg::PayloadSizeMax;
    end else begin
      eff_payload = payload_size_i;
    end
  end

  // Package datapath helpers
  assign len_eff    = (len_q < cipr_pkg::PkgMinLength) ? cipr_pkg::PkgMinLength : len_q;
  assign idx_p1     = {1'b0, byte_q} + 9'd1;
  assign idx_p2     = {1'b0, byte_q} + 9'd2;
  assign emit       = (byte_q >= cipr_pkg::PkgHeadLen) && (idx_p2 < {1'b0, len_eff});
  assign rem_dec    = (emit && (rem_q != 24'd0)) ? rem_q - 24'd1 : rem_q;
  assign pkgnum_inc = pkgnum_q + 16'd1;
  assign ack_hit    = (match_q >= 3'd3) || (b == cipr_pkg::ack_byte(match_q[1:0]));

  // Length of the next package: min(remaining, payload) plus framing
  always_comb begin
    rem_src = (phase_q == PhReply) ? gather_d : rem_dec;
    if (rem_src < {16'd0, eff_payload}) begin
      next_len = rem_src[7:0] + cipr_pkg::PkgOverhead;
    end else begin
      next_len = eff_payload + cipr_pkg::PkgOverhead;
    end
  end

  // Per-byte step
  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    byte_d   = byte_q;
    len_d    = len_q;
    rem_d    = rem_q;
    pkgnum_d = pkgnum_q;
    gather_d = gather_q;
    result_o = '0;

    if (!in_item_i.req_type) begin
      phase_d  = PhAck;
      match_d  = 3'd0;
      byte_d   = 8'd0;
      len_d    = 8'd0;
      rem_d    = 24'd0;
      pkgnum_d = 16'd0;
      gather_d = 24'd0;
    end else begin
      case (phase_q)
        PhAck: begin
          if (ack_hit) begin
            if (match_q >= 3'd5) begin
              match_d  = 3'd0;
              byte_d   = 8'd0;
              gather_d = 24'd0;
              phase_d  = PhReply;
            end else begin
              match_d = match_q + 3'd1;
            end
          end
        end
        PhReply: begin
          case (byte_q[2:0])
            3'd3:    gather_d = gather_q | {16'd0, b};
            3'd4:    gather_d = gather_q | {8'd0, b, 8'd0};
            3'd5:    gather_d = gather_q | {b, 16'd0};
            default: gather_d = gather_q;
          endcase
          byte_d = byte_q + 8'd1;
          if (byte_q >= 8'd5) begin
            result_o.image_size = gather_d;
            result_o.size_valid = 1'b1;
            byte_d = 8'd0;
            if (gather_d == 24'd0) begin
              result_o.size_error = 1'b1;
              phase_d = PhIdle;
            end else begin
              rem_d = gather_d;
              result_o.request_valid   = 1'b1;
              result_o.request_package = pkgnum_q;
              len_d   = next_len;
              phase_d = PhPkg;
            end
          end
        end
        PhPkg: begin
          rem_d = rem_dec;
          if (emit) begin
            result_o.payload_valid = 1'b1;
            result_o.payload_byte  = b;
            result_o.image_last    = (rem_dec == 24'd0);
          end
          if (idx_p1 >= {1'b0, len_eff}) begin
            pkgnum_d = pkgnum_inc;
            byte_d   = 8'd0;
            if (rem_dec == 24'd0) begin
              result_o.goodbye_valid   = 1'b1;
              result_o.request_package = cipr_pkg::GoodbyeCode;
              phase_d = PhIdle;
            end else begin
              result_o.request_valid   = 1'b1;
              result_o.request_package = pkgnum_inc;
              len_d = next_len;
            end
          end else begin
            byte_d = idx_p1[7:0];
          end
        end
        default: begin
          // idle: received bytes are ignored
        end
      endcase
    end
  end

  // State registers, updated only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      match_q  <= 3'd0;
      byte_q   <= 8'd0;
      len_q    <= 8'd0;
      rem_q    <= 24'd0;
      pkgnum_q <= 16'd0;
      gather_q <= 24'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      match_q  <= match_d;
      byte_q   <= byte_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      pkgnum_q <= pkgnum_d;
      gather_q <= gather_d;
    end
  end

endmodule

// ===== design/cipr_out_buf.sv =====
module cipr_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cipr_pkg::out_item_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cipr_pkg::out_item_t out_data_o
);

  logic                out_valid_q;
  logic                skid_valid_q;
  cipr_pkg::out_item_t out_q;
  cipr_pkg::out_item_t skid_q;
  logic                out_free;
  logic                accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control: output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_free) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end
  end

endmodule

// ===== design/camera_image_package_readout.sv =====
// Channel  Direction  Signals                              Accepted when
// in       input      in_valid_i, in_stall_o, in_data_i    in_valid_i && !in_stall_o
// out      output     out_valid_o, out_stall_i, out_data_o out_valid_o && !out_stall_i
// cfg      input      APB psel/penable/pwrite/paddr/pwdata psel && penable && pwrite
//
// One request per cycle unless stalled; its result is registered as output or skid.
// The readout state advances in the same cycle the request is accepted.
// An output register plus one skid entry absorb a stall on the output side;
// in_stall_o rises only when both are full.
// Reset clears the readout state to idle and payload_size to 58.
module camera_image_package_readout (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cipr_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cipr_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cipr_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [7:0]          payload_size_q;
  logic                accept;
  logic                stall;
  cipr_pkg::out_item_t result;

  assign pready         = 1'b1;
  assign in_stall_o     = stall;
  assign accept         = in_valid_i && !stall;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_size_q <= cipr_pkg::PayloadSizeReset;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == cipr_pkg::RegPayloadSize)) begin
      payload_size_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == cipr_pkg::RegPayloadSize) ?
                  {24'd0, payload_size_q} : 32'd0;

  cipr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_item_i      (in_data_i),
    .payload_size_i (payload_size_q),
    .result_o       (result)
  );

  cipr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (stall),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Input side stalls only while the output register is full
  a_stall_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_req_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.goodbye_valid && out_data_o.request_valid))
    else $error("package request and goodbye together");

  a_last_is_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.image_last) |-> out_data_o.payload_valid)
    else $error("image_last without payload byte");

  a_size_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.size_error)
      |-> (out_data_o.size_valid && (out_data_o.image_size == 24'd0)
           && !out_data_o.request_valid))
    else $error("size error with nonzero size or package request");

endmodule
